### rtl/hns_pkg.sv
`timescale 1ns / 1ps
package hns_pkg;

  // field and arithmetic widths
  localparam int H_W   = 16;   // height sample, unsigned Q8.8
  localparam int D_W   = 19;   // signed difference, doubled at borders
  localparam int M_W   = 18;   // magnitude of one vector component
  localparam int L2_W  = 36;   // squared length of the vector
  localparam int T_W   = 68;   // products in the root search
  localparam int N_W   = 15;   // magnitude of a unit component
  localparam int ROW_W = 16;

  // widest address and column the command bus carries
  localparam int ADDR_MAX_W = 13;
  localparam int COL_MAX_W  = 12;

  // 2.0 in Q8.8 and its square
  localparam logic [M_W-1:0]  Y_MAG    = 18'd512;
  localparam logic [L2_W-1:0] LEN_BIAS = 36'd262144;

  // input kinds
  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_FLUSH  = 1'b1;

  // configuration register indexes
  localparam logic [1:0] CFG_GRID_ROWS = 2'd0;
  localparam logic [1:0] CFG_GRID_COLS = 2'd1;

  typedef enum logic [1:0] {
    OPND_A = 2'd0,   // sample one row away, same column
    OPND_B = 2'd1,   // sample of the point itself (drain only)
    OPND_L = 2'd2,   // left neighbor in the point's row
    OPND_R = 2'd3    // right neighbor in the point's row
  } opnd_t;

  typedef enum logic [1:0] {
    COMP_X = 2'd0,
    COMP_Y = 2'd1,
    COMP_Z = 2'd2
  } comp_t;

  typedef enum logic [3:0] {
    OP_NONE  = 4'd0,
    OP_DIFF  = 4'd1,
    OP_SQ    = 4'd2,
    OP_LEN   = 4'd3,
    OP_CINIT = 4'd4,
    OP_CMUL  = 4'd5,
    OP_TRY   = 4'd6,
    OP_KEEP  = 4'd7,
    OP_STORE = 4'd8,
    OP_LOAD  = 4'd9
  } dp_op_t;

  typedef struct packed {
    dp_op_t                  op;
    comp_t                   comp;
    logic [3:0]              bit_k;
    logic                    rd_en;
    opnd_t                   rd_sel;
    logic [ADDR_MAX_W-1:0]   rd_addr;
    logic                    wr_en;
    logic [ADDR_MAX_W-1:0]   wr_addr;
    logic                    job_ld;
    logic                    use_b;
    logic                    dbl_x;
    logic                    dbl_z;
    logic [ROW_W-1:0]        row;
    logic [COL_MAX_W-1:0]    col;
    logic                    done;
  } dp_cmd_t;

  typedef struct packed {
    logic out_busy;
  } dp_stat_t;

endpackage

### rtl/hns_ctrl.sv
`timescale 1ns / 1ps
module hns_ctrl #(
  parameter int MAX_COLS = 256
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  input  logic                in_tuser,
  output logic                in_tready,
  input  logic                cfg_wr_en,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_wdata,
  output hns_pkg::dp_cmd_t    dp_cmd,
  input  hns_pkg::dp_stat_t   dp_stat
);
  import hns_pkg::*;

  localparam int COL_W = $clog2(MAX_COLS);
  localparam int CN_W  = COL_W + 1;
  localparam int AW    = $clog2(2 * MAX_COLS);

  typedef enum logic [11:0] {
    S_IDLE  = 12'b000000000001,
    S_RD    = 12'b000000000010,
    S_WR    = 12'b000000000100,
    S_DIFF  = 12'b000000001000,
    S_SQ    = 12'b000000010000,
    S_LEN   = 12'b000000100000,
    S_CINIT = 12'b000001000000,
    S_CMUL  = 12'b000010000000,
    S_TRY   = 12'b000100000000,
    S_KEEP  = 12'b001000000000,
    S_STORE = 12'b010000000000,
    S_OUT   = 12'b100000000000
  } state_t;

  function automatic logic [AW-1:0] win_addr(input logic slot, input logic [CN_W-1:0] c);
    logic [AW-1:0] base;
    base = slot ? AW'(MAX_COLS) : '0;
    return base + AW'(c);
  endfunction

  state_t            state_r, state_nxt;
  logic [2:0]        step_r, step_nxt;
  comp_t             comp_r, comp_nxt;
  logic [3:0]        k_r, k_nxt;
  logic [15:0]       grid_rows_r, grid_rows_nxt;
  logic [8:0]        grid_cols_r, grid_cols_nxt;
  logic [15:0]       in_row_r, in_row_nxt;
  logic [COL_W-1:0]  in_col_r, in_col_nxt;
  logic [COL_W-1:0]  out_col_r, out_col_nxt;
  logic              draining_r, draining_nxt;
  logic              is_samp_r, is_samp_nxt;
  logic              has_job_r, has_job_nxt;
  logic [AW-1:0]     addr_r [4];
  logic [AW-1:0]     addr_nxt [4];
  logic [AW-1:0]     wr_addr_r, wr_addr_nxt;

  logic [15:0]       nrows;
  logic [CN_W-1:0]   ncols;
  logic [31:0]       gc32;
  logic              samp, accept, take_samp, take_drain;
  logic [CN_W-1:0]   cext, col_l, col_rt;
  logic              col_last;
  logic [15:0]       prow;
  logic              slot_a;

  // effective grid size
  assign gc32  = 32'(grid_cols_r);
  assign nrows = (grid_rows_r < 16'd2) ? 16'd2 : grid_rows_r;
  always_comb begin
    if (gc32 < 32'd2) begin
      ncols = CN_W'(2);
    end else if (gc32 > 32'(MAX_COLS)) begin
      ncols = CN_W'(MAX_COLS);
    end else begin
      ncols = CN_W'(grid_cols_r);
    end
  end

  // stencil placement of the incoming transaction
  assign in_tready  = (state_r == S_IDLE);
  assign accept     = in_tvalid && in_tready;
  assign samp       = (in_tuser == CMD_SAMPLE);
  assign take_samp  = samp && !draining_r && ({1'b0, in_col_r} < ncols);
  assign take_drain = !samp && draining_r;
  assign cext       = samp ? {1'b0, in_col_r} : {1'b0, out_col_r};
  assign prow       = samp ? (in_row_r - 16'd1) : (nrows - 16'd1);
  assign col_last   = (cext + CN_W'(1)) >= ncols;
  assign col_l      = (cext == '0) ? '0 : (cext - CN_W'(1));
  assign col_rt     = (cext == '0) ? CN_W'(1) : (col_last ? cext : (cext + CN_W'(1)));
  assign slot_a     = (samp && (in_row_r == 16'd1)) ? 1'b0 : ~prow[0];

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    comp_nxt      = comp_r;
    k_nxt         = k_r;
    grid_rows_nxt = grid_rows_r;
    grid_cols_nxt = grid_cols_r;
    in_row_nxt    = in_row_r;
    in_col_nxt    = in_col_r;
    out_col_nxt   = out_col_r;
    draining_nxt  = draining_r;
    is_samp_nxt   = is_samp_r;
    has_job_nxt   = has_job_r;
    addr_nxt      = addr_r;
    wr_addr_nxt   = wr_addr_r;
    dp_cmd        = '0;
    dp_cmd.op     = OP_NONE;
    dp_cmd.comp   = comp_r;
    dp_cmd.bit_k  = k_r;
    dp_cmd.rd_sel = opnd_t'(step_r[1:0]);
    dp_cmd.rd_addr = ADDR_MAX_W'(addr_r[step_r[1:0]]);
    dp_cmd.wr_addr = ADDR_MAX_W'(wr_addr_r);
    dp_cmd.use_b  = !samp;
    dp_cmd.dbl_x  = !samp || (in_row_r == 16'd1);
    dp_cmd.dbl_z  = (cext == '0) || col_last;
    dp_cmd.row    = prow;
    dp_cmd.col    = COL_MAX_W'(cext);
    dp_cmd.done   = !samp && col_last;

    case (state_r)
      S_IDLE: begin
        if (accept && (take_samp || take_drain)) begin
          step_nxt    = '0;
          is_samp_nxt = take_samp;
          addr_nxt[0] = win_addr(slot_a, cext);
          addr_nxt[1] = win_addr(prow[0], cext);
          addr_nxt[2] = win_addr(prow[0], col_l);
          addr_nxt[3] = win_addr(prow[0], col_rt);
          wr_addr_nxt = win_addr(in_row_r[0], {1'b0, in_col_r});
          dp_cmd.job_ld = 1'b1;
          if (take_samp) begin
            has_job_nxt = (in_row_r != 16'd0);
            state_nxt   = (in_row_r != 16'd0) ? S_RD : S_WR;
            if (col_last) begin
              in_col_nxt = '0;
              in_row_nxt = in_row_r + 16'd1;
              if ((17'(in_row_r) + 17'd1) >= 17'(nrows)) begin
                draining_nxt = 1'b1;
                out_col_nxt  = '0;
              end
            end else begin
              in_col_nxt = in_col_r + COL_W'(1);
            end
          end else begin
            has_job_nxt = 1'b1;
            state_nxt   = S_RD;
            if (col_last) begin
              in_row_nxt   = '0;
              in_col_nxt   = '0;
              out_col_nxt  = '0;
              draining_nxt = 1'b0;
            end else begin
              out_col_nxt = out_col_r + COL_W'(1);
            end
          end
        end
      end
      // four window reads; the data of each lands in the cycle after its address
      S_RD: begin
        dp_cmd.rd_en = (step_r != 3'd4);
        step_nxt     = step_r + 3'd1;
        if (step_r == 3'd4) begin
          state_nxt = S_WR;
        end
      end
      S_WR: begin
        dp_cmd.wr_en = is_samp_r;
        state_nxt    = has_job_r ? S_DIFF : S_IDLE;
      end
      S_DIFF: begin
        dp_cmd.op = OP_DIFF;
        state_nxt = S_SQ;
      end
      S_SQ: begin
        dp_cmd.op = OP_SQ;
        state_nxt = S_LEN;
      end
      S_LEN: begin
        dp_cmd.op = OP_LEN;
        comp_nxt  = COMP_X;
        state_nxt = S_CINIT;
      end
      S_CINIT: begin
        dp_cmd.op = OP_CINIT;
        state_nxt = S_CMUL;
      end
      S_CMUL: begin
        dp_cmd.op = OP_CMUL;
        k_nxt     = 4'd14;
        state_nxt = S_TRY;
      end
      S_TRY: begin
        dp_cmd.op = OP_TRY;
        state_nxt = S_KEEP;
      end
      S_KEEP: begin
        dp_cmd.op = OP_KEEP;
        if (k_r == 4'd0) begin
          state_nxt = S_STORE;
        end else begin
          k_nxt     = k_r - 4'd1;
          state_nxt = S_TRY;
        end
      end
      S_STORE: begin
        dp_cmd.op = OP_STORE;
        case (comp_r)
          COMP_X: begin
            comp_nxt  = COMP_Y;
            state_nxt = S_CINIT;
          end
          COMP_Y: begin
            comp_nxt  = COMP_Z;
            state_nxt = S_CINIT;
          end
          default: begin
            state_nxt = S_OUT;
          end
        endcase
      end
      S_OUT: begin
        if (!dp_stat.out_busy) begin
          dp_cmd.op = OP_LOAD;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // a write to grid_rows or grid_cols restarts the stream
    if (cfg_wr_en && ((cfg_index == CFG_GRID_ROWS) || (cfg_index == CFG_GRID_COLS))) begin
      if (cfg_index == CFG_GRID_ROWS) begin
        grid_rows_nxt = cfg_wdata;
      end else begin
        grid_cols_nxt = cfg_wdata[8:0];
      end
      in_row_nxt   = '0;
      in_col_nxt   = '0;
      out_col_nxt  = '0;
      draining_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      comp_r      <= COMP_X;
      k_r         <= '0;
      grid_rows_r <= 16'd2;
      grid_cols_r <= 9'd2;
      in_row_r    <= '0;
      in_col_r    <= '0;
      out_col_r   <= '0;
      draining_r  <= 1'b0;
      is_samp_r   <= 1'b0;
      has_job_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      comp_r      <= comp_nxt;
      k_r         <= k_nxt;
      grid_rows_r <= grid_rows_nxt;
      grid_cols_r <= grid_cols_nxt;
      in_row_r    <= in_row_nxt;
      in_col_r    <= in_col_nxt;
      out_col_r   <= out_col_nxt;
      draining_r  <= draining_nxt;
      is_samp_r   <= is_samp_nxt;
      has_job_r   <= has_job_nxt;
    end
  end

  // window addresses of the current point
  always_ff @(posedge clk) begin
    addr_r    <= addr_nxt;
    wr_addr_r <= wr_addr_nxt;
  end

endmodule

### rtl/hns_dp.sv
`timescale 1ns / 1ps
module hns_dp #(
  parameter int MAX_COLS = 256
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  hns_pkg::dp_cmd_t                       dp_cmd,
  output hns_pkg::dp_stat_t                      dp_stat,
  input  logic [hns_pkg::H_W-1:0]                in_height,
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  output logic [((63 + $clog2(MAX_COLS) + 7) / 8) * 8 - 1:0] out_tdata,
  output logic                                   out_tlast
);
  import hns_pkg::*;

  localparam int COL_W = $clog2(MAX_COLS);
  localparam int AW    = $clog2(2 * MAX_COLS);
  localparam int OUT_W = ((63 + COL_W + 7) / 8) * 8;

  // two-row height window
  logic [H_W-1:0]   mem [2 * MAX_COLS];
  logic [H_W-1:0]   rdata_r;
  logic             rd_vld_r;
  opnd_t            rd_sel_r;

  logic [H_W-1:0]   a_r, b_r, l_r, rt_r, h_r;
  logic             use_b_r, dbl_x_r, dbl_z_r, done_r;
  logic [ROW_W-1:0] row_r;
  logic [COL_W-1:0] col_r;

  logic signed [D_W-1:0]   sx_r, sz_r, sx_nxt, sz_nxt;
  logic signed [D_W-1:0]   dx, dz;
  logic signed [2*D_W-1:0] px, pz;
  logic [L2_W-1:0]  sx2_r, sz2_r, len2_r;
  logic [M_W-1:0]   mag_r, mag_nxt;
  logic             neg_r, neg_nxt;
  logic [2*M_W-1:0] mag2_r;
  logic [T_W-1:0]   t2, lenx, try_r, ml_r, m2l_r;
  logic [4:0]       sh1, sh2, sh4;
  logic [N_W-1:0]   n_r;
  logic [15:0]      nx_r, nz_r, nsig;
  logic [14:0]      ny_r;
  logic             out_valid_r;
  logic [OUT_W-1:0] out_data_r;
  logic             out_last_r;

  always_ff @(posedge clk) begin
    if (dp_cmd.wr_en) begin
      mem[dp_cmd.wr_addr[AW-1:0]] <= h_r;
    end
    if (dp_cmd.rd_en) begin
      rdata_r <= mem[dp_cmd.rd_addr[AW-1:0]];
    end
    rd_sel_r <= dp_cmd.rd_sel;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= dp_cmd.rd_en;
    end
  end

  // operand capture and job fields
  always_ff @(posedge clk) begin
    if (rd_vld_r) begin
      case (rd_sel_r)
        OPND_A:  a_r  <= rdata_r;
        OPND_B:  b_r  <= rdata_r;
        OPND_L:  l_r  <= rdata_r;
        default: rt_r <= rdata_r;
      endcase
    end
    if (dp_cmd.job_ld) begin
      h_r     <= in_height;
      use_b_r <= dp_cmd.use_b;
      dbl_x_r <= dp_cmd.dbl_x;
      dbl_z_r <= dp_cmd.dbl_z;
      done_r  <= dp_cmd.done;
      row_r   <= dp_cmd.row;
      col_r   <= dp_cmd.col[COL_W-1:0];
    end
  end

  // differences and squares
  always_comb begin
    dx     = $signed({3'b000, (use_b_r ? b_r : h_r)}) - $signed({3'b000, a_r});
    dz     = $signed({3'b000, rt_r}) - $signed({3'b000, l_r});
    sx_nxt = dbl_x_r ? (dx <<< 1) : dx;
    sz_nxt = dbl_z_r ? (dz <<< 1) : dz;
    px     = sx_r * sx_r;
    pz     = sz_r * sz_r;
  end

  // component setup
  always_comb begin
    case (dp_cmd.comp)
      COMP_X: begin
        neg_nxt = (sx_r > 0);
        mag_nxt = M_W'(sx_r[D_W-1] ? -sx_r : sx_r);
      end
      COMP_Y: begin
        neg_nxt = 1'b0;
        mag_nxt = Y_MAG;
      end
      default: begin
        neg_nxt = sz_r[D_W-1];
        mag_nxt = M_W'(sz_r[D_W-1] ? -sz_r : sz_r);
      end
    endcase
  end

  // root search terms: odd = m + 2*bit - 1 with m = 2n
  assign t2   = T_W'({mag2_r, 30'd0});
  assign lenx = T_W'(len2_r);
  assign sh1  = 5'(dp_cmd.bit_k) + 5'd1;
  assign sh2  = 5'(dp_cmd.bit_k) + 5'd2;
  assign sh4  = {dp_cmd.bit_k, 1'b0} + 5'd2;
  assign nsig = neg_r ? (16'd0 - {1'b0, n_r}) : {1'b0, n_r};

  always_ff @(posedge clk) begin
    case (dp_cmd.op)
      OP_DIFF: begin
        sx_r <= sx_nxt;
        sz_r <= sz_nxt;
      end
      OP_SQ: begin
        sx2_r <= px[L2_W-1:0];
        sz2_r <= pz[L2_W-1:0];
      end
      OP_LEN: begin
        len2_r <= sx2_r + sz2_r + LEN_BIAS;
      end
      OP_CINIT: begin
        mag_r <= mag_nxt;
        neg_r <= neg_nxt;
        ml_r  <= '0;
        m2l_r <= '0;
        n_r   <= '0;
      end
      OP_CMUL: begin
        mag2_r <= mag_r * mag_r;
      end
      OP_TRY: begin
        try_r <= m2l_r + (ml_r << sh2) - (ml_r << 1) + (lenx << sh4) - (lenx << sh2) + lenx;
      end
      OP_KEEP: begin
        if (try_r <= t2) begin
          n_r   <= n_r | (N_W'(1) << dp_cmd.bit_k);
          ml_r  <= ml_r + (lenx << sh1);
          m2l_r <= m2l_r + (ml_r << sh2) + (lenx << sh4);
        end
      end
      OP_STORE: begin
        case (dp_cmd.comp)
          COMP_X:  nx_r <= nsig;
          COMP_Y:  ny_r <= n_r;
          default: nz_r <= nsig;
        endcase
      end
      default: begin
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (dp_cmd.op == OP_LOAD) begin
      out_data_r <= OUT_W'({col_r, row_r, nz_r, ny_r, nx_r});
      out_last_r <= done_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (dp_cmd.op == OP_LOAD) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_tvalid       = out_valid_r;
  assign out_tdata        = out_data_r;
  assign out_tlast        = out_last_r;
  assign dp_stat.out_busy = out_valid_r && !out_tready;

endmodule

### rtl/heightmap_normal_stencil_core.sv
`timescale 1ns / 1ps
// channel   direction  signals                      contents
// in_*      input      tvalid tready tdata tuser    tdata: height; tuser: cmd
// out_*     output     tvalid tready tdata tlast    tdata: normal, row, col; tlast: grid_done
// cfg_*     input      wr_en index wdata            0 grid_rows, 1 grid_cols
//
// one item at a time: a result takes 4 window reads, one write, difference
// and length steps, then a bit-serial root search over 15 bits for each of
// the 3 components, all in the shared root search unit.
// rst_n is synchronous; the height window holds no reset and needs no clear.
// a result waiting in the output register holds the next finished result,
// and the input with it.
module heightmap_normal_stencil_core #(
  parameter int MAX_COLS = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] height
  input  logic        in_tuser,   // [0] cmd
  output logic        out_tvalid,
  input  logic        out_tready,
  // [15:0] normal_x, [30:16] normal_y, [46:31] normal_z, [62:47] row, then col
  output logic [((63 + $clog2(MAX_COLS) + 7) / 8) * 8 - 1:0] out_tdata,
  output logic        out_tlast,  // grid_done
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);
  import hns_pkg::*;

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  hns_ctrl #(
    .MAX_COLS (MAX_COLS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tuser  (in_tuser),
    .in_tready (in_tready),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .dp_cmd    (dp_cmd),
    .dp_stat   (dp_stat)
  );

  hns_dp #(
    .MAX_COLS (MAX_COLS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .dp_cmd     (dp_cmd),
    .dp_stat    (dp_stat),
    .in_height  (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

`ifndef SYNTHESIS
  // a stalled result holds steady until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=>
      (out_tvalid && $stable(out_tdata) && $stable(out_tlast)))
    else $error("stalled result changed");

  // a new result never overwrites one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (dp_cmd.op == OP_LOAD) |-> !(out_tvalid && !out_tready))
    else $error("result loaded over a pending result");

  // the window is never read and written in the same cycle
  a_port_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(dp_cmd.rd_en && dp_cmd.wr_en))
    else $error("window read and write collide");
`endif

endmodule

### dv/tb_heightmap_normal_stencil_core.sv
`timescale 1ns / 1ps
module tb_heightmap_normal_stencil_core;
  import hns_pkg::*;

  localparam int NCOLS_MAX = 256;
  localparam int OUT_W = ((63 + $clog2(NCOLS_MAX) + 7) / 8) * 8;
  localparam logic [1:0] CFG_SPARE = 2'd3;  // no register behind this index
  localparam int SETTLE = 300;

  typedef struct {
    logic        cmd;
    logic [15:0] height;
  } hmap_item_t;

  typedef struct {
    logic [15:0] nx;
    logic [14:0] ny;
    logic [15:0] nz;
    logic [15:0] row;
    logic [7:0]  col;
    logic        done;
  } normal_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [15:0] in_tdata = '0;
  logic in_tuser = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;
  logic out_tlast;
  logic cfg_wr_en = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [15:0] cfg_wdata = '0;

  hmap_item_t sample_q[$];
  normal_t    normals_due[$];
  int errors = 0;
  int send_idle = 0;
  int recv_idle = 0;
  int cycle_cnt = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  int n_items = 0;

  // shadow of the block state
  logic [15:0] hwin[2*NCOLS_MAX];
  logic [15:0] rows_reg, cols_reg;
  int unsigned pos_row, pos_col, drain_col;
  bit draining;

  heightmap_normal_stencil_core #(.MAX_COLS(NCOLS_MAX)) uut (.*);

  always #10 clk = ~clk;

  function automatic int unsigned eff_rows();
    return (rows_reg < 2) ? 2 : rows_reg;
  endfunction

  function automatic int unsigned eff_cols();
    if (cols_reg < 2) return 2;
    if (cols_reg > NCOLS_MAX) return NCOLS_MAX;
    return cols_reg;
  endfunction

  function automatic longint hwin_rd(int unsigned r, int unsigned c);
    return longint'(hwin[(r & 1) * NCOLS_MAX + c]);
  endfunction

  function automatic void restart_stream();
    pos_row = 0;
    pos_col = 0;
    drain_col = 0;
    draining = 0;
  endfunction

  // row-wise difference with one-sided doubling at the edges
  function automatic longint row_slope(int unsigned r, int unsigned c, int unsigned nc);
    if (c == 0) return 2 * (hwin_rd(r, 1) - hwin_rd(r, 0));
    if (c >= nc - 1) return 2 * (hwin_rd(r, c) - hwin_rd(r, c - 1));
    return hwin_rd(r, c + 1) - hwin_rd(r, c - 1);
  endfunction

  // q1.14 of v/sqrt(len2), round to nearest with ties away from zero
  function automatic logic [15:0] unit_q14(longint v, longint unsigned len2);
    longint unsigned mag, t, q, n, cand, odd;
    mag = (v < 0) ? longint'(-v) : longint'(v);
    t = 64'd32768 * mag;
    q = (t * t) / len2;
    n = 0;
    for (int b = 14; b >= 0; b--) begin
      cand = n | (64'd1 << b);
      odd = 2 * cand - 1;
      if (odd * odd <= q) n = cand;
    end
    if (v < 0) n = -n;
    return n[15:0];
  endfunction

  function automatic void push_normal(longint sx, longint sz, int unsigned r,
                                      int unsigned c, bit done);
    normal_t e;
    logic [15:0] y;
    longint unsigned len2;
    len2 = longint'(sx * sx) + longint'(sz * sz) + 64'd262144;
    y = unit_q14(512, len2);
    e.nx = unit_q14(-sx, len2);
    e.ny = y[14:0];
    e.nz = unit_q14(sz, len2);
    e.row = r[15:0];
    e.col = c[7:0];
    e.done = done;
    normals_due.push_back(e);
  endfunction

  // advance the shadow state by one accepted transaction
  function automatic void predict_normal(logic cmd, logic [15:0] h);
    int unsigned nr, nc, r, c, pr;
    longint below, sx;
    bit done;
    nr = eff_rows();
    nc = eff_cols();
    if (cmd == CMD_SAMPLE) begin
      r = pos_row;
      c = pos_col;
      if (draining || c >= nc) return;
      if (r >= 1) begin
        pr = r - 1;
        below = (pr == 0) ? hwin_rd(pr, c) : hwin_rd(r, c);
        sx = longint'(h) - below;
        if (pr == 0) sx = sx * 2;
        push_normal(sx, row_slope(pr, c, nc), pr, c, 0);
      end
      hwin[(r & 1) * NCOLS_MAX + c] = h;
      if (c + 1 >= nc) begin
        pos_col = 0;
        pos_row = r + 1;
        if (pos_row >= nr) begin
          draining = 1;
          drain_col = 0;
        end
      end else begin
        pos_col = c + 1;
      end
    end else begin
      if (!draining) return;
      r = nr - 1;
      c = drain_col;
      if (c >= nc) begin
        restart_stream();
        return;
      end
      sx = 2 * (hwin_rd(r, c) - hwin_rd(r - 1, c));
      done = (c + 1 >= nc);
      push_normal(sx, row_slope(r, c, nc), r, c, done);
      if (done) restart_stream();
      else drain_col = c + 1;
    end
  endfunction

  // input driver
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) predict_normal(in_tuser, in_tdata);
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (sample_q.size() > 0 && $urandom_range(99) >= send_idle) begin
        in_tvalid <= 1'b1;
        in_tuser <= sample_q[0].cmd;
        in_tdata <= sample_q[0].height;
        void'(sample_q.pop_front());
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // result monitor and receiver back-pressure
  always @(posedge clk) begin
    normal_t e;
    cycle_cnt <= cycle_cnt + 1;
    if (rst_n && out_tvalid && out_tready) begin
      if (normals_due.size() == 0) begin
        $error("unexpected normal transaction, tdata %h", out_tdata);
        errors++;
      end else begin
        e = normals_due.pop_front();
        if (out_tdata[15:0] !== e.nx) begin
          $error("normal_x exp %h got %h", e.nx, out_tdata[15:0]); errors++;
        end
        if (out_tdata[30:16] !== e.ny) begin
          $error("normal_y exp %h got %h", e.ny, out_tdata[30:16]); errors++;
        end
        if (out_tdata[46:31] !== e.nz) begin
          $error("normal_z exp %h got %h", e.nz, out_tdata[46:31]); errors++;
        end
        if (out_tdata[62:47] !== e.row) begin
          $error("row exp %0d got %0d", e.row, out_tdata[62:47]); errors++;
        end
        if (out_tdata[70:63] !== e.col) begin
          $error("col exp %0d got %0d", e.col, out_tdata[70:63]); errors++;
        end
        if (out_tlast !== e.done) begin
          $error("grid_done exp %0d got %0d", e.done, out_tlast); errors++;
        end
      end
    end
    // one long hold-off while the sender still has items, so the block backs up
    if (!hold_done && cycle_cnt >= 4000 && sample_q.size() > 2) begin
      hold_done <= 1'b1;
      hold_left <= 900;
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle);
    end
  end

  task automatic wait_idle();
    while (sample_q.size() > 0 || in_tvalid || normals_due.size() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    if (idx == CFG_GRID_ROWS) begin
      rows_reg = val;
      restart_stream();
    end else if (idx == CFG_GRID_COLS) begin
      cols_reg = 16'(val[8:0]);
      restart_stream();
    end
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  function automatic void add_item(logic cmd, logic [15:0] h);
    hmap_item_t it;
    it.cmd = cmd;
    it.height = h;
    sample_q.push_back(it);
    n_items++;
  endfunction

  // one grid with random heights, optional noise and truncation
  task automatic queue_grid(int unsigned nr, int unsigned nc, bit noisy, bit cut);
    int unsigned stop;
    stop = cut ? $urandom_range(nr * nc - 1, 1) : nr * nc;
    for (int unsigned i = 0; i < stop; i++) begin
      if (noisy && $urandom_range(99) < 4) add_item(CMD_FLUSH, 16'($urandom));
      add_item(CMD_SAMPLE, ($urandom_range(9) == 0) ? {16{1'($urandom_range(1))}}
                                                    : 16'($urandom));
    end
    if (cut) return;
    if (noisy && $urandom_range(99) < 30)
      repeat ($urandom_range(2, 1)) add_item(CMD_SAMPLE, 16'($urandom));
    for (int unsigned i = 0; i < nc; i++) add_item(CMD_FLUSH, 16'($urandom));
    if (noisy && $urandom_range(99) < 20) add_item(CMD_FLUSH, 16'($urandom));
  endtask

  initial begin
    int unsigned nr, nc;
    for (int i = 0; i < 2 * NCOLS_MAX; i++) hwin[i] = '0;
    rows_reg = 16'd2;
    cols_reg = 16'd2;
    restart_stream();
    send_idle = 32;
    recv_idle = 60;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // default 2x2 grid: early flush, extreme heights, sample during drain
    add_item(CMD_FLUSH, 16'hffff);
    add_item(CMD_SAMPLE, 16'h0000);
    add_item(CMD_SAMPLE, 16'hffff);
    add_item(CMD_SAMPLE, 16'hffff);
    add_item(CMD_SAMPLE, 16'h0000);
    add_item(CMD_SAMPLE, 16'h1234);
    add_item(CMD_FLUSH, 16'h0000);
    add_item(CMD_FLUSH, 16'h0000);
    add_item(CMD_FLUSH, 16'h0000);
    wait_idle();

    // values below the minimum, then a flat 3x3 with a spike in the middle
    write_reg(CFG_GRID_ROWS, 16'd0);
    write_reg(CFG_GRID_COLS, 16'd1);
    write_reg(CFG_SPARE, 16'hffff);
    add_item(CMD_SAMPLE, 16'hffff);
    add_item(CMD_SAMPLE, 16'h0000);
    add_item(CMD_SAMPLE, 16'h0000);
    add_item(CMD_SAMPLE, 16'hffff);
    add_item(CMD_FLUSH, 16'h0);
    add_item(CMD_FLUSH, 16'h0);
    wait_idle();
    write_reg(CFG_GRID_ROWS, 16'd3);
    write_reg(CFG_GRID_COLS, 16'd3);
    for (int i = 0; i < 9; i++) add_item(CMD_SAMPLE, (i == 4) ? 16'hffff : 16'h0000);
    repeat (3) add_item(CMD_FLUSH, 16'h0);
    wait_idle();

    // random grids, mostly small and complete
    while (n_items < 250) begin
      if (n_items < 130) begin
        send_idle = 32; recv_idle = 60;
      end else begin
        send_idle = 60; recv_idle = 32;
      end
      nr = $urandom_range(6, 2);
      nc = ($urandom_range(9) == 0) ? $urandom_range(24, 13) : $urandom_range(12, 2);
      write_reg(CFG_GRID_ROWS, 16'(nr));
      write_reg(CFG_GRID_COLS, 16'(nc));
      repeat ($urandom_range(3, 1))
        queue_grid(nr, nc, 1, $urandom_range(9) == 0);
      wait_idle();
    end

    // widest grid, with a column value above the maximum, no idling
    send_idle = 0;
    recv_idle = 0;
    write_reg(CFG_GRID_ROWS, 16'd2);
    write_reg(CFG_GRID_COLS, 16'h01ff);
    queue_grid(2, NCOLS_MAX, 0, 0);
    wait_idle();
    write_reg(CFG_GRID_COLS, 16'd256);
    write_reg(CFG_GRID_ROWS, 16'hffff);
    queue_grid(2, NCOLS_MAX, 0, 1);
    wait_idle();

    if (errors == 0 && normals_due.size() == 0) begin
      $display("tb_heightmap_normal_stencil_core passed");
    end else begin
      if (normals_due.size() > 0) $error("%0d normals never arrived", normals_due.size());
      $display("tb_heightmap_normal_stencil_core failed");
    end
    $finish;
  end

  // run limit
  initial begin
    #80_000_000;
    $display("tb_heightmap_normal_stencil_core failed");
    $finish;
  end

endmodule

### heightmap_normal_stencil_core.f
rtl/hns_pkg.sv
rtl/hns_ctrl.sv
rtl/hns_dp.sv
rtl/heightmap_normal_stencil_core.sv
dv/tb_heightmap_normal_stencil_core.sv
